### sv/imufp_pkg.sv
`default_nettype none

package imufp_pkg;

  // Payload store depth and derived widths
  localparam int MAX_PAYLOAD = 28;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

  // Frame bytes
  localparam logic [7:0] SYNC_A = 8'h55;
  localparam logic [7:0] SYNC_B = 8'hAF;
  localparam logic [7:0] ID_ATT = 8'h01;
  localparam logic [7:0] ID_RAW = 8'h03;

  // Result kinds
  localparam logic KIND_ATT = 1'b0;
  localparam logic KIND_RAW = 1'b1;

  // Result tdata width: roll, pitch, yaw total, three accel, three gyro words
  localparam int OUT_W = 160;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5
  } phase_t;

endpackage

`default_nettype wire

### sv/imu_frame_parser_attitude_decode.sv
// Inertial sensor frame parser with attitude decode.
// Input channel (in_*): one received serial byte per beat on in_tdata.
// Frames are 0x55, 0x55 or 0xAF, id, length (0..28), payload, checksum;
// the checksum is the low byte of the sum of all earlier frame bytes.
// Result channel (out_*): one beat per good frame with id 1 (attitude:
// roll, pitch, unwrapped 32-bit yaw total) or id 3 (accel and gyro words).
// out_tuser carries the kind: 0 attitude, 1 raw inertial.
// Latency: the result beat is valid the cycle after its checksum byte is
// taken. Throughput: one byte per cycle; the only stall on the input is a
// checksum byte arriving while a previous result is still held in the
// output register and out_tready is low. All other bytes are taken
// regardless of the output side.
// Reset (rst_n low, synchronous): parser waits for a first sync byte, the
// payload store and yaw history are cleared, and no result is pending.
// A frame with fewer payload bytes than it decodes (6 for attitude, 12 for
// raw inertial) decodes stale bytes from earlier frames (zero after reset).

`default_nettype none

module imu_frame_parser_attitude_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] rx_byte
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  // [15:0] roll_angle, [31:16] pitch_angle, [63:32] yaw_total,
  // [79:64] accel_x, [95:80] accel_y, [111:96] accel_z,
  // [127:112] gyro_x, [143:128] gyro_y, [159:144] gyro_z
  output      logic [imufp_pkg::OUT_W-1:0] out_tdata,
  output      logic                        out_tuser   // [0] frame_kind
);

  localparam logic signed [17:0] HALF_TURN = 18'sd32768;
  localparam logic signed [17:0] FULL_TURN = 18'sd65536;

  // Parser state
  imufp_pkg::phase_t               phase_r, phase_nxt;
  logic [7:0]                      sum_r, sum_nxt;
  logic [7:0]                      id_r, id_nxt;
  logic [imufp_pkg::IDX_W-1:0]     len_r, len_nxt;
  logic [imufp_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [7:0]                      pay_r [imufp_pkg::MAX_PAYLOAD];
  logic                            st_we;
  logic                            emit;

  // Yaw history
  logic                            yaw_seen_r;
  logic [15:0]                     last_yaw_r;
  logic [31:0]                     yaw_sum_r, yaw_sum_nxt;

  // Result register
  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [imufp_pkg::OUT_W-1:0]     out_data_r;

  logic                            in_fire;
  logic [15:0]                     cur_yaw;
  logic signed [17:0]              yaw_diff, yaw_delta;
  logic                            len_ok;
  logic [imufp_pkg::IDX_W-1:0]     idx_inc;

  // Only a checksum byte can produce a result, so only it waits on the output
  assign in_tready = (phase_r != imufp_pkg::PH_CSUM) || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign len_ok  = {1'b0, in_tdata} <= 9'(imufp_pkg::MAX_PAYLOAD);
  assign idx_inc = idx_r + 1'b1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        imufp_pkg::PH_SYNC2: begin
          if (in_tdata == imufp_pkg::SYNC_A || in_tdata == imufp_pkg::SYNC_B) begin
            phase_nxt = imufp_pkg::PH_ID;
          end else begin
            phase_nxt = imufp_pkg::PH_SYNC1;
          end
        end
        imufp_pkg::PH_ID: phase_nxt = imufp_pkg::PH_LEN;
        imufp_pkg::PH_LEN: begin
          if (!len_ok) begin
            phase_nxt = imufp_pkg::PH_SYNC1;
          end else if (in_tdata == 8'd0) begin
            phase_nxt = imufp_pkg::PH_CSUM;
          end else begin
            phase_nxt = imufp_pkg::PH_DATA;
          end
        end
        imufp_pkg::PH_DATA: begin
          if (idx_inc >= len_r) begin
            phase_nxt = imufp_pkg::PH_CSUM;
          end
        end
        imufp_pkg::PH_CSUM: phase_nxt = imufp_pkg::PH_SYNC1;
        default: begin
          if (in_tdata == imufp_pkg::SYNC_A) begin
            phase_nxt = imufp_pkg::PH_SYNC2;
          end else begin
            phase_nxt = imufp_pkg::PH_SYNC1;
          end
        end
      endcase
    end
  end

  // Per-phase datapath controls
  always_comb begin
    sum_nxt = sum_r;
    id_nxt  = id_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    st_we   = 1'b0;
    emit    = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        imufp_pkg::PH_SYNC2: begin
          if (in_tdata == imufp_pkg::SYNC_A || in_tdata == imufp_pkg::SYNC_B) begin
            sum_nxt = sum_r + in_tdata;
          end
        end
        imufp_pkg::PH_ID: begin
          id_nxt  = in_tdata;
          sum_nxt = sum_r + in_tdata;
        end
        imufp_pkg::PH_LEN: begin
          if (len_ok) begin
            len_nxt = in_tdata[imufp_pkg::IDX_W-1:0];
            sum_nxt = sum_r + in_tdata;
            idx_nxt = '0;
          end
        end
        imufp_pkg::PH_DATA: begin
          st_we   = idx_r < imufp_pkg::IDX_W'(imufp_pkg::MAX_PAYLOAD);
          idx_nxt = idx_inc;
          sum_nxt = sum_r + in_tdata;
        end
        imufp_pkg::PH_CSUM: begin
          emit = (sum_r == in_tdata)
                 && (id_r == imufp_pkg::ID_ATT || id_r == imufp_pkg::ID_RAW);
        end
        default: begin
          if (in_tdata == imufp_pkg::SYNC_A) begin
            sum_nxt = in_tdata;
          end
        end
      endcase
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= imufp_pkg::PH_SYNC1;
      sum_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload store, cleared at reset
  for (genvar i = 0; i < imufp_pkg::MAX_PAYLOAD; i++) begin : g_pay
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pay_r[i] <= '0;
      end else if (st_we && idx_r[imufp_pkg::ADDR_W-1:0] == imufp_pkg::ADDR_W'(i)) begin
        pay_r[i] <= in_tdata;
      end
    end
  end

  // Yaw unwrap: delta folded into one half turn either way
  assign cur_yaw  = {pay_r[5], pay_r[4]};
  assign yaw_diff = $signed({{2{cur_yaw[15]}}, cur_yaw})
                    - $signed({{2{last_yaw_r[15]}}, last_yaw_r});

  always_comb begin
    if (yaw_diff > HALF_TURN) begin
      yaw_delta = yaw_diff - FULL_TURN;
    end else if (yaw_diff < -HALF_TURN) begin
      yaw_delta = yaw_diff + FULL_TURN;
    end else begin
      yaw_delta = yaw_diff;
    end
    if (!yaw_seen_r) begin
      yaw_sum_nxt = '0;
    end else begin
      yaw_sum_nxt = yaw_sum_r + {{14{yaw_delta[17]}}, yaw_delta};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_seen_r <= 1'b0;
      last_yaw_r <= '0;
      yaw_sum_r  <= '0;
    end else if (emit && id_r == imufp_pkg::ID_ATT) begin
      yaw_seen_r <= 1'b1;
      last_yaw_r <= cur_yaw;
      yaw_sum_r  <= yaw_sum_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (id_r == imufp_pkg::ID_ATT) begin
        out_kind_r <= imufp_pkg::KIND_ATT;
        out_data_r <= {96'd0, yaw_sum_nxt, pay_r[3], pay_r[2], pay_r[1], pay_r[0]};
      end else begin
        out_kind_r <= imufp_pkg::KIND_RAW;
        out_data_r <= {pay_r[11], pay_r[10], pay_r[9], pay_r[8], pay_r[7], pay_r[6],
                       pay_r[5], pay_r[4], pay_r[3], pay_r[2], pay_r[1], pay_r[0],
                       64'd0};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // A byte outside the checksum phase never creates a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r != imufp_pkg::PH_CSUM && !out_valid_r) |=> !out_valid_r)
    else $error("result raised by a non-checksum byte");

  // While collecting payload the index stays below the frame length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == imufp_pkg::PH_DATA) |-> (idx_r < len_r))
    else $error("payload index past frame length");

  // Raw inertial results carry no attitude words
  a_raw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == imufp_pkg::KIND_RAW) |-> (out_data_r[63:0] == 64'd0))
    else $error("attitude fields set on a raw inertial result");

endmodule

`default_nettype wire
